>>> hw/rtl/rhb_pkg.sv
// Shared types, constants and step functions for the radial halo brighten pipeline.
package rhb_pkg;

   localparam int MaxDim = 4096;

   // configuration register indexes
   localparam logic [1:0] CSR_IMAGE_WIDTH   = 2'd0;
   localparam logic [1:0] CSR_IMAGE_HEIGHT  = 2'd1;
   localparam logic [1:0] CSR_HALO_STRENGTH = 2'd2;

   localparam logic [12:0] ResetWidth    = 13'd640;
   localparam logic [12:0] ResetHeight   = 13'd480;
   localparam logic [8:0]  ResetStrength = 9'd80;

   // pipeline stage map
   localparam int StSquare    = 1;
   localparam int StDist      = 2;
   localparam int SqrtSteps   = 27;
   localparam int SqrtFirst   = 3;
   localparam int SqrtLast    = SqrtFirst + SqrtSteps - 1;
   localparam int StDiff      = SqrtLast + 1;
   localparam int StMul       = StDiff + 1;
   localparam int DivSteps    = 9;
   localparam int DivFirst    = StMul + 1;
   localparam int DivLast     = DivFirst + DivSteps - 1;
   localparam int StOut       = DivLast + 1;
   localparam int NumStages   = StOut + 1;

   typedef struct packed {
      logic [7:0]  blue;
      logic [7:0]  green;
      logic [7:0]  red;
      logic        neg;
      logic [8:0]  mag;
      logic [11:0] radius;
      logic [22:0] rr;
      logic [11:0] adx;
      logic [11:0] ady;
      logic [23:0] sqx;
      logic [23:0] sqy;
      logic        in_halo;
      logic [53:0] rad;
      logic [30:0] rem;
      logic [26:0] root;
      logic [35:0] num;
      logic [8:0]  quo;
   } pipe_type;

   // one digit of the square root: consumes the top two radicand bits
   function automatic pipe_type sqrt_step(input pipe_type p);
      pipe_type   q;
      logic [30:0] trial_rem;
      logic [30:0] trial;
      q = p;
      trial_rem = {p.rem[28:0], p.rad[53:52]};
      trial     = {2'b00, p.root, 2'b01};
      q.rad     = {p.rad[51:0], 2'b00};
      if (trial_rem >= trial) begin
         q.rem  = trial_rem - trial;
         q.root = {p.root[25:0], 1'b1};
      end else begin
         q.rem  = trial_rem;
         q.root = {p.root[25:0], 1'b0};
      end
      return q;
   endfunction

   // one restoring step of num / (radius << 16), quotient bit k
   function automatic pipe_type div_step(input pipe_type p, input int k);
      pipe_type    q;
      logic [36:0] dk;
      q = p;
      dk = 37'(p.radius) << (16 + k);
      if ({1'b0, p.num} >= dk) begin
         q.num = p.num - dk[35:0];
         q.quo = p.quo | (9'd1 << k);
      end
      return q;
   endfunction

   function automatic logic [7:0] clamp_add(input logic [7:0] ch, input logic signed [10:0] off);
      logic signed [10:0] v;
      v = $signed({3'b000, ch}) + off;
      if (v < 0)
         return 8'd0;
      else if (v > 11'sd255)
         return 8'd255;
      else
         return v[7:0];
   endfunction

endpackage

>>> hw/rtl/radial_halo_brighten_core.sv
// Top level: radial halo brightness pipeline, one pixel word per clock unless rsp_stall holds it.
//
//  channel | ports                        | role
//  --------+------------------------------+-------------------------------
//  req     | req_valid/req_stall + fields | pixel word in (column,row,bgr)
//  rsp     | rsp_valid/rsp_stall + fields | brightened pixel word out
//  csr     | csr_write/index/data         | width, height, strength
//
// One word enters and leaves per clock unless rsp_stall holds it. The 27-stage
// square root and the 9-stage restoring divider set the depth.
// Reset clears all stage valid bits and loads the register defaults.
// rsp_stall on a valid output word freezes the whole pipeline and raises
// req_stall in the same cycle.
module radial_halo_brighten_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [11:0] req_column,
   input  logic [11:0] req_row,
   input  logic [7:0]  req_pixel_blue,
   input  logic [7:0]  req_pixel_green,
   input  logic [7:0]  req_pixel_red,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_blue,
   output logic [7:0]  rsp_out_green,
   output logic [7:0]  rsp_out_red,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_data
);
   import rhb_pkg::*;

   logic [12:0] width_ff, height_ff;
   logic [8:0]  strength_ff;

   pipe_type stage_ff [NumStages];
   pipe_type stage_in [NumStages];
   logic [NumStages-1:0] valid_ff, valid_in;
   logic advance;

   logic [12:0] w_sat, h_sat;
   logic [11:0] cx, cy, rad_r;
   logic [24:0] dist_sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= ResetWidth;
         height_ff   <= ResetHeight;
         strength_ff <= ResetStrength;
      end else if (csr_write) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:   width_ff    <= csr_data;
            CSR_IMAGE_HEIGHT:  height_ff   <= csr_data;
            CSR_HALO_STRENGTH: strength_ff <= csr_data[8:0];
            default: ;
         endcase
      end
   end

   assign w_sat = (width_ff > 13'(MaxDim)) ? 13'(MaxDim) : width_ff;
   assign h_sat = (height_ff > 13'(MaxDim)) ? 13'(MaxDim) : height_ff;
   assign cx    = w_sat[12:1];
   assign cy    = h_sat[12:1];
   assign rad_r = (cx < cy) ? cx : cy;
   assign dist_sum = {1'b0, stage_ff[StSquare].sqx} + {1'b0, stage_ff[StSquare].sqy};

   assign advance   = !valid_ff[NumStages-1] || !rsp_stall;
   assign req_stall = !advance;

   always_comb begin
      stage_in[0]        = stage_ff[0];
      stage_in[0].blue   = req_pixel_blue;
      stage_in[0].green  = req_pixel_green;
      stage_in[0].red    = req_pixel_red;
      stage_in[0].neg    = strength_ff[8];
      stage_in[0].mag    = strength_ff[8] ? (9'd0 - strength_ff) : strength_ff;
      stage_in[0].radius = rad_r;
      stage_in[0].rr     = 23'(rad_r * rad_r);
      stage_in[0].adx    = (req_column >= cx) ? (req_column - cx) : (cx - req_column);
      stage_in[0].ady    = (req_row >= cy) ? (req_row - cy) : (cy - req_row);
      valid_in[0]        = req_valid;
      for (int i = 1; i < NumStages; i++) begin
         stage_in[i] = stage_ff[i-1];
         valid_in[i] = valid_ff[i-1];
         if (i == StSquare) begin
            stage_in[i].sqx = stage_ff[i-1].adx * stage_ff[i-1].adx;
            stage_in[i].sqy = stage_ff[i-1].ady * stage_ff[i-1].ady;
         end else if (i == StDist) begin
            stage_in[i].in_halo = (stage_ff[i-1].radius != 12'd0)
                                  && (dist_sum < {2'b00, stage_ff[i-1].rr});
            stage_in[i].rad    = {dist_sum[21:0], 32'd0};
            stage_in[i].rem    = '0;
            stage_in[i].root   = '0;
         end else if (i >= SqrtFirst && i <= SqrtLast) begin
            stage_in[i] = sqrt_step(stage_ff[i-1]);
         end else if (i == StDiff) begin
            stage_in[i].num = 36'({stage_ff[i-1].radius, 16'd0})
                              - 36'(stage_ff[i-1].root);
         end else if (i == StMul) begin
            stage_in[i].num = 36'(stage_ff[i-1].mag * stage_ff[i-1].num[27:0]);
            stage_in[i].quo = '0;
         end else if (i >= DivFirst && i <= DivLast) begin
            stage_in[i] = div_step(stage_ff[i-1], DivLast - i);
         end else if (i == StOut) begin
            logic signed [10:0] off;
            off = '0;
            if (stage_ff[i-1].in_halo)
               off = stage_ff[i-1].neg ? -$signed({2'b00, stage_ff[i-1].quo})
                                       :  $signed({2'b00, stage_ff[i-1].quo});
            stage_in[i].blue  = clamp_add(stage_ff[i-1].blue, off);
            stage_in[i].green = clamp_add(stage_ff[i-1].green, off);
            stage_in[i].red   = clamp_add(stage_ff[i-1].red, off);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < NumStages; i++)
            stage_ff[i] <= stage_in[i];
      end
   end

   assign rsp_valid     = valid_ff[NumStages-1];
   assign rsp_out_blue  = stage_ff[NumStages-1].blue;
   assign rsp_out_green = stage_ff[NumStages-1].green;
   assign rsp_out_red   = stage_ff[NumStages-1].red;

endmodule

>>> hw/rtl/rhb_checker.sv
// Port-level checker for the radial halo brighten core, with its bind.
module rhb_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_blue,
   input logic [7:0] rsp_out_green,
   input logic [7:0] rsp_out_red
);

   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_blue)
         && $stable(rsp_out_green) && $stable(rsp_out_red))
      else $error("stalled rsp word changed");

   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("req taken while rsp stalled");

   a_free_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("req stalled with free output");

endmodule

bind radial_halo_brighten_core rhb_checker u_rhb_checker (
   .clock(clock), .reset(reset), .req_stall(req_stall), .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall), .rsp_out_blue(rsp_out_blue),
   .rsp_out_green(rsp_out_green), .rsp_out_red(rsp_out_red)
);
